// ----- rtl/iuc_pkg.sv -----
// Shared types and constants for the interval union coverage unit.
// Holds the controller/datapath command and status structs and the fixed port widths.
// No dependencies.
package iuc_pkg;

    localparam int FIELD_W     = 16;
    localparam int ROAD_W      = 16;
    localparam int COUNT_OUT_W = 5;

    typedef struct packed {
        logic load;        // capture a well-formed item and open a scan
        logic issue;       // read the next stored entry
        logic flush;       // write the pending interval
        logic finish;      // commit the new table and post the result
        logic report_bad;  // post the result for an inverted item
    } iuc_cmd_t;

    typedef struct packed {
        logic in_bad;      // start exceeds end on the input ports
        logic more;        // entries remain to be read
    } iuc_status_t;

endpackage

// ----- rtl/iuc_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
// Used for both table banks of the interval union coverage unit; no dependencies.
module iuc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/iuc_ctrl.sv -----
// Controller of the interval union coverage unit: sequences load, scan, flush and finish, and reports inverted items.
// Depends on iuc_pkg for the command and status structs.
module iuc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  iuc_pkg::iuc_status_t status,
    output iuc_pkg::iuc_cmd_t    cmd,
    output logic                 busy
);
    import iuc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (status.in_bad)
                    begin
                        cmd.report_bad = 1'b1;
                    end
                    else
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // The last read returns in the cycle that sees no more entries.
                if (status.more)
                begin
                    cmd.issue = 1'b1;
                end
                else
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                cmd.flush  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    a_flush_then_finish: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FLUSH |=> state_reg == ST_FINISH)
        else $error("flush not followed by finish");

    a_load_enters_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == ST_SCAN)
        else $error("load did not start a scan");

endmodule

// ----- rtl/iuc_datapath.sv -----
// Datapath of the interval union coverage unit: two ping-pong table banks, the merge
// and compaction logic, the coverage sum and the result registers.
// Depends on iuc_pkg and iuc_ram.
module iuc_datapath #(
    parameter int MAX_INTERVALS = 16,
    parameter int COORD_BITS    = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  iuc_pkg::iuc_cmd_t                 cmd,
    output iuc_pkg::iuc_status_t              status,
    input  logic [iuc_pkg::FIELD_W-1:0]       interval_start,
    input  logic [iuc_pkg::FIELD_W-1:0]       interval_end,
    input  logic                              cfg_we,
    input  logic [iuc_pkg::ROAD_W-1:0]        cfg_data,
    output logic                              result_valid,
    output logic [iuc_pkg::ROAD_W-1:0]        uncovered_count,
    output logic [iuc_pkg::COUNT_OUT_W-1:0]   stored_intervals,
    output logic                              table_full,
    output logic                              bad_order
);
    import iuc_pkg::*;

    localparam int CB   = COORD_BITS;
    localparam int AW   = $clog2(MAX_INTERVALS);
    localparam int CNTW = $clog2(MAX_INTERVALS + 1);
    localparam int SW   = (CB + 1 > ROAD_W) ? CB + 1 : ROAD_W;
    localparam logic [CNTW-1:0] MAX_CNT = CNTW'(MAX_INTERVALS);

    // Input coordinates reduced to the table width.
    logic [31:0]   in_s_wide;
    logic [31:0]   in_e_wide;
    logic [CB-1:0] in_s;
    logic [CB-1:0] in_e;

    assign in_s_wide = 32'(interval_start);
    assign in_e_wide = 32'(interval_end);
    assign in_s      = in_s_wide[CB-1:0];
    assign in_e      = in_e_wide[CB-1:0];

    // Control state.
    logic [ROAD_W-1:0] road_reg,       road_next;
    logic [CNTW-1:0]   count_reg,      count_next;
    logic [CB:0]       cov_reg,        cov_next;
    logic              bank_reg,       bank_next;
    logic [CNTW-1:0]   idx_reg,        idx_next;
    logic [CNTW-1:0]   n_reg,          n_next;
    logic [CB:0]       sum_reg,        sum_next;
    logic              hit_reg,        hit_next;
    logic              placed_reg,     placed_next;
    logic              data_valid_reg, data_valid_next;
    logic              valid_reg,      valid_next;

    // Payload.
    logic [CB-1:0]          s_reg,       s_next;
    logic [CB-1:0]          e_reg,       e_next;
    logic [CB-1:0]          lo_reg,      lo_next;
    logic [CB-1:0]          hi_reg,      hi_next;
    logic [CB-1:0]          carry_s_reg, carry_s_next;
    logic [CB-1:0]          carry_e_reg, carry_e_next;
    logic [ROAD_W-1:0]      uncov_reg,   uncov_next;
    logic [COUNT_OUT_W-1:0] stored_reg,  stored_next;
    logic                   full_reg,    full_next;
    logic                   bad_reg,     bad_next;

    // Table banks: one is read while the compacted table is written into the other.
    logic [2*CB-1:0] rd_data_a;
    logic [2*CB-1:0] rd_data_b;
    logic [2*CB-1:0] rd_data;
    logic [CB-1:0]   x_s;
    logic [CB-1:0]   x_e;
    logic            wr_req;
    logic            wr_en;
    logic [CB-1:0]   wr_s;
    logic [CB-1:0]   wr_e;
    logic [CB:0]     span;
    logic            drop;
    logic [CB:0]     cov_out;
    logic [CNTW-1:0] count_out;
    logic [SW-1:0]   road_ext;
    logic [SW-1:0]   cov_ext;
    logic [SW-1:0]   diff;
    logic [31:0]     count_wide;

    iuc_ram #(
        .WIDTH(2 * CB),
        .DEPTH(MAX_INTERVALS)
    ) u_bank_a (
        .clk    (clk),
        .wr_en  (wr_en && bank_reg),
        .wr_addr(n_reg[AW-1:0]),
        .wr_data({wr_s, wr_e}),
        .rd_en  (cmd.issue && !bank_reg),
        .rd_addr(idx_reg[AW-1:0]),
        .rd_data(rd_data_a)
    );

    iuc_ram #(
        .WIDTH(2 * CB),
        .DEPTH(MAX_INTERVALS)
    ) u_bank_b (
        .clk    (clk),
        .wr_en  (wr_en && !bank_reg),
        .wr_addr(n_reg[AW-1:0]),
        .wr_data({wr_s, wr_e}),
        .rd_en  (cmd.issue && bank_reg),
        .rd_addr(idx_reg[AW-1:0]),
        .rd_data(rd_data_b)
    );

    assign rd_data = bank_reg ? rd_data_b : rd_data_a;
    assign x_s     = rd_data[2*CB-1:CB];
    assign x_e     = rd_data[CB-1:0];

    assign status.in_bad = (in_s > in_e);
    assign status.more   = (idx_reg < count_reg);

    always_comb
    begin
        road_next       = road_reg;
        count_next      = count_reg;
        cov_next        = cov_reg;
        bank_next       = bank_reg;
        idx_next        = idx_reg;
        n_next          = n_reg;
        sum_next        = sum_reg;
        hit_next        = hit_reg;
        placed_next     = placed_reg;
        data_valid_next = cmd.issue;
        valid_next      = 1'b0;
        s_next          = s_reg;
        e_next          = e_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        carry_s_next    = carry_s_reg;
        carry_e_next    = carry_e_reg;
        uncov_next      = uncov_reg;
        stored_next     = stored_reg;
        full_next       = full_reg;
        bad_next        = bad_reg;
        wr_req          = 1'b0;
        wr_s            = lo_reg;
        wr_e            = hi_reg;

        if (cfg_we)
        begin
            road_next = cfg_data;
        end

        if (cmd.load)
        begin
            s_next      = in_s;
            e_next      = in_e;
            lo_next     = in_s;
            hi_next     = in_e;
            hit_next    = 1'b0;
            placed_next = 1'b0;
            n_next      = '0;
            sum_next    = '0;
            idx_next    = '0;
        end

        if (cmd.issue)
        begin
            idx_next = idx_reg + CNTW'(1);
        end

        if (data_valid_reg)
        begin
            if (placed_reg)
            begin
                // After the merged interval is out, entries go out via the carry.
                wr_req       = 1'b1;
                wr_s         = carry_s_reg;
                wr_e         = carry_e_reg;
                carry_s_next = x_s;
                carry_e_next = x_e;
            end
            else if (x_e < s_reg)
            begin
                wr_req = 1'b1;
                wr_s   = x_s;
                wr_e   = x_e;
            end
            else if (x_s <= e_reg)
            begin
                hit_next = 1'b1;
                lo_next  = (x_s < lo_reg) ? x_s : lo_reg;
                hi_next  = (x_e > hi_reg) ? x_e : hi_reg;
            end
            else
            begin
                wr_req       = 1'b1;
                placed_next  = 1'b1;
                carry_s_next = x_s;
                carry_e_next = x_e;
            end
        end

        if (cmd.flush)
        begin
            wr_req = 1'b1;
            if (placed_reg)
            begin
                wr_s = carry_s_reg;
                wr_e = carry_e_reg;
            end
        end

        // Requests past the last slot only come from a dropped item and are masked.
        wr_en = wr_req && (n_reg < MAX_CNT);
        span  = {1'b0, wr_e} - {1'b0, wr_s} + (CB+1)'(1);
        if (wr_en)
        begin
            n_next   = n_reg + CNTW'(1);
            sum_next = sum_reg + span;
        end

        drop      = !hit_reg && (count_reg == MAX_CNT);
        cov_out   = cov_reg;
        count_out = count_reg;
        if (cmd.finish && !drop)
        begin
            cov_out    = sum_reg;
            count_out  = n_reg;
            cov_next   = sum_reg;
            count_next = n_reg;
            bank_next  = !bank_reg;
        end

        road_ext   = SW'(road_reg);
        cov_ext    = SW'(cov_out);
        diff       = road_ext - cov_ext;
        count_wide = 32'(count_out);

        if (cmd.finish || cmd.report_bad)
        begin
            valid_next  = 1'b1;
            uncov_next  = (road_ext > cov_ext) ? diff[ROAD_W-1:0] : '0;
            stored_next = count_wide[COUNT_OUT_W-1:0];
            full_next   = cmd.finish && drop;
            bad_next    = cmd.report_bad;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            road_reg       <= '0;
            count_reg      <= '0;
            cov_reg        <= '0;
            bank_reg       <= 1'b0;
            idx_reg        <= '0;
            n_reg          <= '0;
            sum_reg        <= '0;
            hit_reg        <= 1'b0;
            placed_reg     <= 1'b0;
            data_valid_reg <= 1'b0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            road_reg       <= road_next;
            count_reg      <= count_next;
            cov_reg        <= cov_next;
            bank_reg       <= bank_next;
            idx_reg        <= idx_next;
            n_reg          <= n_next;
            sum_reg        <= sum_next;
            hit_reg        <= hit_next;
            placed_reg     <= placed_next;
            data_valid_reg <= data_valid_next;
            valid_reg      <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg       <= s_next;
        e_reg       <= e_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        carry_s_reg <= carry_s_next;
        carry_e_reg <= carry_e_next;
        uncov_reg   <= uncov_next;
        stored_reg  <= stored_next;
        full_reg    <= full_next;
        bad_reg     <= bad_next;
    end

    assign result_valid     = valid_reg;
    assign uncovered_count  = uncov_reg;
    assign stored_intervals = stored_reg;
    assign table_full       = full_reg;
    assign bad_order        = bad_reg;

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> !(full_reg && bad_reg))
        else $error("table_full and bad_order both set");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("entry count exceeds table depth");

    a_flush_after_reads: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |-> !data_valid_reg)
        else $error("flush overlaps a pending table read");

endmodule

// ----- rtl/interval_union_coverage_unit.sv -----
// Interval union coverage unit: merges each interval into a sorted table of disjoint intervals.
// The scan reads one table entry per cycle from a single RAM read port, then a flush and a
// finish state post the result; the report of an inverted item appears in the next cycle.
// A new item is taken only while busy is low; busy is high through scan, flush and finish.
// Reset clears the table count, the covered total and road_length; table RAM is not cleared.
// Results are strobed for one cycle and cannot be stalled. Depends on iuc_pkg, iuc_ctrl, iuc_datapath.
module interval_union_coverage_unit #(
    parameter int MAX_INTERVALS = 16,
    parameter int COORD_BITS    = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [iuc_pkg::FIELD_W-1:0]     interval_start,
    input  logic [iuc_pkg::FIELD_W-1:0]     interval_end,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [iuc_pkg::ROAD_W-1:0]      cfg_data,
    output logic                            result_valid,
    output logic [iuc_pkg::ROAD_W-1:0]      uncovered_count,
    output logic [iuc_pkg::COUNT_OUT_W-1:0] stored_intervals,
    output logic                            table_full,
    output logic                            bad_order
);
    import iuc_pkg::*;

    iuc_cmd_t    cmd;
    iuc_status_t status;

    // Configuration transfers are taken whenever no item is in flight.
    assign cfg_ready = !busy;

    iuc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .status(status),
        .cmd   (cmd),
        .busy  (busy)
    );

    iuc_datapath #(
        .MAX_INTERVALS(MAX_INTERVALS),
        .COORD_BITS   (COORD_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .interval_start  (interval_start),
        .interval_end    (interval_end),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_data        (cfg_data),
        .result_valid    (result_valid),
        .uncovered_count (uncovered_count),
        .stored_intervals(stored_intervals),
        .table_full      (table_full),
        .bad_order       (bad_order)
    );

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for interval_union_coverage_unit: directed table, then random phases.
// An in-bench predictor of the sorted interval table supplies the expected reports, but for pinned directed rows.
// Depends on iuc_pkg and the unit's RTL only.
module tb;
    import iuc_pkg::*;

    localparam int MAX_SPANS = 16;
    localparam int COORD_MAX = 65535;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int N_PHASES = 5;
    localparam int N_ROWS = 25;

    typedef struct packed {
        logic [ROAD_W-1:0]      uncovered;
        logic [COUNT_OUT_W-1:0] stored;
        logic                   full;
        logic                   bad;
    } coverage_report_t;

    typedef enum logic {ROW_ITEM, ROW_ROAD} row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        logic [15:0]      first;    // interval start, or road length for a register row
        logic [15:0]      last;
        logic             pinned;   // the report below is typed in by hand
        coverage_report_t rep;
    } stim_row_t;

    // Walks the table through inserts, abutting neighbors, merges and enclosure until it
    // holds sixteen entries, then shows a drop on a full table and a merge that is still taken.
    localparam stim_row_t DIRECTED [0:N_ROWS-1] = '{
        '{ROW_ITEM, 16'd10,    16'd5,     1'b1, '{16'd0,     5'd0,  1'b0, 1'b1}},
        '{ROW_ITEM, 16'd0,     16'd0,     1'b1, '{16'd0,     5'd1,  1'b0, 1'b0}},
        '{ROW_ROAD, 16'd65535, 16'd0,     1'b0, '0},
        '{ROW_ITEM, 16'd65535, 16'd65535, 1'b1, '{16'd65533, 5'd2,  1'b0, 1'b0}},
        '{ROW_ITEM, 16'd65535, 16'd0,     1'b1, '{16'd65533, 5'd2,  1'b0, 1'b1}},
        '{ROW_ITEM, 16'd1000,  16'd1010,  1'b0, '0},
        '{ROW_ITEM, 16'd1011,  16'd1020,  1'b0, '0},
        '{ROW_ITEM, 16'd990,   16'd1000,  1'b0, '0},
        '{ROW_ITEM, 16'd995,   16'd1015,  1'b0, '0},
        '{ROW_ITEM, 16'd500,   16'd2000,  1'b0, '0},
        '{ROW_ITEM, 16'd4096,  16'd4096,  1'b0, '0},
        '{ROW_ITEM, 16'd8192,  16'd8193,  1'b0, '0},
        '{ROW_ITEM, 16'd12288, 16'd12290, 1'b0, '0},
        '{ROW_ITEM, 16'd16384, 16'd16387, 1'b0, '0},
        '{ROW_ITEM, 16'd20480, 16'd20484, 1'b0, '0},
        '{ROW_ITEM, 16'd24576, 16'd24581, 1'b0, '0},
        '{ROW_ITEM, 16'd28672, 16'd28678, 1'b0, '0},
        '{ROW_ITEM, 16'd32768, 16'd32775, 1'b0, '0},
        '{ROW_ITEM, 16'd36864, 16'd36872, 1'b0, '0},
        '{ROW_ITEM, 16'd40960, 16'd40969, 1'b0, '0},
        '{ROW_ITEM, 16'd45056, 16'd45066, 1'b0, '0},
        '{ROW_ITEM, 16'd49152, 16'd49163, 1'b0, '0},
        '{ROW_ITEM, 16'd53248, 16'd53260, 1'b0, '0},
        '{ROW_ITEM, 16'd60000, 16'd60010, 1'b1, '{16'd63941, 5'd16, 1'b1, 1'b0}},
        '{ROW_ITEM, 16'd4090,  16'd4100,  1'b0, '0}
    };

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [FIELD_W-1:0]     interval_start;
    logic [FIELD_W-1:0]     interval_end;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [ROAD_W-1:0]      cfg_data;
    logic                   result_valid;
    logic [ROAD_W-1:0]      uncovered_count;
    logic [COUNT_OUT_W-1:0] stored_intervals;
    logic                   table_full;
    logic                   bad_order;

    // Predicted contents of the unit's table.
    logic [15:0]      span_lo [MAX_SPANS];
    logic [15:0]      span_hi [MAX_SPANS];
    int unsigned      span_count = 0;
    logic [16:0]      covered_pts = '0;
    logic [15:0]      road_len = '0;

    coverage_report_t pending_reports [$];
    int               idle_pct = 0;
    int               errors = 0;

    interval_union_coverage_unit #(
        .MAX_INTERVALS(MAX_SPANS),
        .COORD_BITS   (16)
    ) uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .interval_start  (interval_start),
        .interval_end    (interval_end),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .result_valid    (result_valid),
        .uncovered_count (uncovered_count),
        .stored_intervals(stored_intervals),
        .table_full      (table_full),
        .bad_order       (bad_order)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [15:0] clamp16(input int v);
        if (v < 0)
            return 16'd0;
        if (v > COORD_MAX)
            return 16'hFFFF;
        return v[15:0];
    endfunction

    // Merges one interval into the predicted table and forms the report it produces.
    task automatic absorb_interval(input logic [15:0] s, input logic [15:0] e,
                                   output coverage_report_t rep);
        logic [15:0] nlo [MAX_SPANS];
        logic [15:0] nhi [MAX_SPANS];
        int unsigned n;
        int unsigned i;
        logic [15:0] lo;
        logic [15:0] hi;
        logic        hit;
        logic [16:0] sum;
        rep = '0;
        if (s > e)
        begin
            rep.bad = 1'b1;
        end
        else
        begin
            n = 0;
            i = 0;
            lo = s;
            hi = e;
            hit = 1'b0;
            while (i < span_count && span_hi[i] < s)
            begin
                nlo[n] = span_lo[i];
                nhi[n] = span_hi[i];
                n++;
                i++;
            end
            while (i < span_count && span_lo[i] <= e)
            begin
                hit = 1'b1;
                if (span_lo[i] < lo)
                    lo = span_lo[i];
                if (span_hi[i] > hi)
                    hi = span_hi[i];
                i++;
            end
            if (!hit && span_count >= MAX_SPANS)
            begin
                rep.full = 1'b1;
            end
            else
            begin
                nlo[n] = lo;
                nhi[n] = hi;
                n++;
                while (i < span_count && n < MAX_SPANS)
                begin
                    nlo[n] = span_lo[i];
                    nhi[n] = span_hi[i];
                    n++;
                    i++;
                end
                sum = '0;
                for (int k = 0; k < n; k++)
                begin
                    span_lo[k] = nlo[k];
                    span_hi[k] = nhi[k];
                    sum = sum + {1'b0, nhi[k]} - {1'b0, nlo[k]} + 17'd1;
                end
                span_count = n;
                covered_pts = sum;
            end
        end
        rep.uncovered = ({1'b0, road_len} > covered_pts) ? 16'({1'b0, road_len} - covered_pts)
                                                         : 16'd0;
        rep.stored = span_count[COUNT_OUT_W-1:0];
    endtask

    // Presents one interval, holding start until the unit takes it, then records the
    // expected report. Start is left high so a following item can go out back to back.
    task automatic send_item(input logic [15:0] s, input logic [15:0] e,
                             input logic pinned, input coverage_report_t pinned_rep);
        int               gap;
        coverage_report_t rep;
        gap = 0;
        while (idle_pct != 0 && $urandom_range(99, 0) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        interval_start <= s;
        interval_end <= e;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        absorb_interval(s, e, rep);
        pending_reports.insert(pending_reports.size(), pinned ? pinned_rep : rep);
    endtask

    // Road length is only rewritten once every report has come back.
    task automatic write_road(input logic [15:0] value);
        start <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        road_len = value;
    endtask

    // Random items are mostly shaped around the entries already held, so that overlaps,
    // abutting neighbors and multi-entry merges keep happening on a full table.
    task automatic pick_interval(output logic [15:0] s, output logic [15:0] e);
        int sel;
        int k;
        int m;
        int p;
        int lo_i;
        int hi_i;
        sel = $urandom_range(99, 0);
        if (span_count == 0 && sel >= 30 && sel < 85)
            sel = 20;
        k = (span_count == 0) ? 0 : $urandom_range(span_count - 1, 0);
        if (sel < 8)
        begin
            lo_i = $urandom_range(COORD_MAX - 1, 0);
            hi_i = $urandom_range(COORD_MAX, lo_i + 1);
        end
        else if (sel < 30)
        begin
            lo_i = $urandom_range(COORD_MAX, 0);
            hi_i = lo_i + $urandom_range(7, 0);
        end
        else if (sel < 60)
        begin
            p = $urandom_range(span_hi[k], span_lo[k]);
            lo_i = p - $urandom_range(8, 0);
            hi_i = p + $urandom_range(8, 0);
        end
        else if (sel < 72)
        begin
            if ($urandom_range(1, 0) == 1)
            begin
                lo_i = span_hi[k] + 1 + $urandom_range(40, 0);
                hi_i = lo_i + $urandom_range(4, 0);
            end
            else
            begin
                hi_i = span_lo[k] - 1 - $urandom_range(40, 0);
                lo_i = hi_i - $urandom_range(4, 0);
            end
        end
        else if (sel < 85)
        begin
            m = k + $urandom_range(3, 1);
            if (m > span_count - 1)
                m = span_count - 1;
            lo_i = span_lo[k] - $urandom_range(4, 0);
            hi_i = span_hi[m] + $urandom_range(4, 0);
            if (hi_i - lo_i > 1024)
                hi_i = span_hi[k];
        end
        else
        begin
            lo_i = $urandom_range(COORD_MAX, 0);
            hi_i = lo_i + $urandom_range(1023, 0);
        end
        if (sel < 8)
        begin
            s = clamp16(hi_i);
            e = clamp16(lo_i);
        end
        else
        begin
            s = clamp16(lo_i);
            e = clamp16(hi_i);
        end
    endtask

    always @(posedge clk)
    begin
        coverage_report_t want;
        if (rst_n && result_valid)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("report with no item outstanding: uncovered_count=%0d", uncovered_count);
                errors++;
            end
            else
            begin
                want = pending_reports.pop_front();
                if (uncovered_count !== want.uncovered)
                begin
                    $error("uncovered_count: expected %0d, got %0d", want.uncovered,
                           uncovered_count);
                    errors++;
                end
                if (stored_intervals !== want.stored)
                begin
                    $error("stored_intervals: expected %0d, got %0d", want.stored,
                           stored_intervals);
                    errors++;
                end
                if (table_full !== want.full)
                begin
                    $error("table_full: expected %0b, got %0b", want.full, table_full);
                    errors++;
                end
                if (bad_order !== want.bad)
                begin
                    $error("bad_order: expected %0b, got %0b", want.bad, bad_order);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int               phase_pct [N_PHASES];
        logic [15:0]      phase_road [N_PHASES];
        logic [15:0]      s;
        logic [15:0]      e;
        phase_pct = '{0, 79, 14, 0, 79};
        phase_road = '{16'($urandom_range(COORD_MAX, 0)), 16'd65535, 16'd300, 16'd0, 16'd1};
        rst_n = 1'b0;
        start = 1'b0;
        interval_start = '0;
        interval_end = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < N_ROWS; r++)
        begin
            if (DIRECTED[r].kind == ROW_ROAD)
                write_road(DIRECTED[r].first);
            else
                send_item(DIRECTED[r].first, DIRECTED[r].last, DIRECTED[r].pinned,
                          DIRECTED[r].rep);
        end

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            write_road(phase_road[ph]);
            idle_pct = phase_pct[ph];
            repeat (ITEMS_PER_PHASE)
            begin
                pick_interval(s, e);
                send_item(s, e, 1'b0, '0);
            end
        end

        // Last of all, one interval spanning every coordinate swallows the whole table.
        send_item(16'd0, 16'hFFFF, 1'b0, '0);
        start <= 1'b0;
        for (int w = 0; w < 2000 && pending_reports.size() != 0; w++)
            @(posedge clk);
        repeat (24) @(posedge clk);
        if (pending_reports.size() != 0)
        begin
            $error("%0d reports never arrived", pending_reports.size());
            errors++;
        end
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
